FILE: sv/apjb_pkg.sv
// ----------------------------------------------------------------------------
// apjb_pkg: shared types and constants of the audio playout jitter buffer
// Item layouts for both channels, status and register codes, reset values.
// ----------------------------------------------------------------------------
package apjb_pkg;

    localparam int SAMPLE_W = 16;
    localparam int FRAME_W  = 2 * SAMPLE_W;
    localparam int FILL_W   = 11;

    // item kinds
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    // register indexes
    localparam logic REG_STREAMING = 1'b0;
    localparam logic REG_PREFILL   = 1'b1;

    localparam logic [FILL_W-1:0] PREFILL_RESET = 11'd768;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_DROP   = 2'd1,
        ST_UNDER  = 2'd2,
        ST_SILENT = 2'd3
    } status_t;

    typedef struct packed {
        logic                       kind;
        logic signed [SAMPLE_W-1:0] left_in;
        logic signed [SAMPLE_W-1:0] right_in;
        logic                       block_start;
    } req_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
        logic                       fresh;
        status_t                    status;
        logic [FILL_W-1:0]          fill_level;
    } rsp_item_t;

    // result of one item as decided at accept time
    typedef struct packed {
        logic              fresh;
        status_t           status;
        logic              show_frame;
        logic [FILL_W-1:0] fill_level;
    } result_t;

    // configuration state seen by the control logic
    typedef struct packed {
        logic              streaming_on;
        logic [FILL_W-1:0] prefill_frames;
        logic              clear;
    } cfg_t;

endpackage

FILE: sv/apjb_cfg.sv
// ----------------------------------------------------------------------------
// apjb_cfg: configuration registers
// APB-style register file holding streaming_on and prefill_frames.
// ----------------------------------------------------------------------------
module apjb_cfg
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    output apjb_pkg::cfg_t          cfg
);
    import apjb_pkg::*;

    logic              streaming_reg;
    logic [FILL_W-1:0] prefill_reg;
    logic              wr_en;
    logic              aligned;
    logic              reg_idx;

    assign pready  = 1'b1;
    assign aligned = (paddr[1:0] == 2'b00);
    assign reg_idx = paddr[2];
    assign wr_en   = psel && penable && pwrite && aligned;

    // write the registers on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            streaming_reg <= 1'b0;
            prefill_reg   <= PREFILL_RESET;
        end
        else if (wr_en)
        begin
            if (reg_idx == REG_STREAMING)
            begin
                streaming_reg <= pwdata[0];
            end
            else
            begin
                prefill_reg <= pwdata[FILL_W-1:0];
            end
        end
    end

    // read back the addressed register
    always_comb
    begin
        prdata = 32'd0;
        if (aligned)
        begin
            if (reg_idx == REG_STREAMING)
            begin
                prdata = {31'd0, streaming_reg};
            end
            else
            begin
                prdata = {{(32-FILL_W){1'b0}}, prefill_reg};
            end
        end
    end

    // a streaming write clears the FIFO at the same edge
    assign cfg.streaming_on   = streaming_reg;
    assign cfg.prefill_frames = prefill_reg;
    assign cfg.clear          = wr_en && (reg_idx == REG_STREAMING);

endmodule

FILE: sv/apjb_frame_ram.sv
// ----------------------------------------------------------------------------
// apjb_frame_ram: frame store
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module apjb_frame_ram
#(
    parameter int DEPTH = 1536,
    parameter int AW    = 11
)
(
    input  logic                        clk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [apjb_pkg::FRAME_W-1:0] wdata,
    input  logic                        re,
    input  logic [AW-1:0]               raddr,
    output logic [apjb_pkg::FRAME_W-1:0] rdata
);
    import apjb_pkg::*;

    logic [FRAME_W-1:0] mem [DEPTH];

    // store on write, load the read register only on a read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: sv/apjb_ctrl.sv
// ----------------------------------------------------------------------------
// apjb_ctrl: FIFO pointers and playback control
// Decides each transaction at accept time and updates slots, count and flags.
// ----------------------------------------------------------------------------
module apjb_ctrl
#(
    parameter int FIFO_FRAMES = 1536,
    parameter int AW          = 11,
    parameter int CW          = 11
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  apjb_pkg::req_item_t          item,
    input  apjb_pkg::cfg_t               cfg,
    output logic                         mem_we,
    output logic [AW-1:0]                mem_waddr,
    output logic [apjb_pkg::FRAME_W-1:0] mem_wdata,
    output logic                         mem_re,
    output logic [AW-1:0]                mem_raddr,
    output apjb_pkg::result_t            result
);
    import apjb_pkg::*;

    localparam int CMPW = (CW > FILL_W) ? CW : FILL_W;
    localparam logic [AW-1:0] LAST_SLOT = AW'(FIFO_FRAMES - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(FIFO_FRAMES);

    logic [AW-1:0] rd_reg, rd_next, rd_eff;
    logic [AW-1:0] wr_reg, wr_next, wr_eff;
    logic [CW-1:0] cnt_reg, cnt_next, cnt_eff;
    logic          primed_reg, primed_next, primed_eff;
    logic          silent_reg, silent_next;
    logic          hzero_reg, hzero_next, hzero_eff;

    logic is_pop;
    logic blk;
    logic clear_now;
    logic below_prefill;

    // decide the transaction
    always_comb
    begin
        is_pop    = (item.kind == KIND_POP);
        blk       = is_pop && item.block_start;
        clear_now = blk && !cfg.streaming_on;

        rd_eff     = clear_now ? '0 : rd_reg;
        wr_eff     = clear_now ? '0 : wr_reg;
        cnt_eff    = clear_now ? '0 : cnt_reg;
        primed_eff = clear_now ? 1'b0 : primed_reg;
        hzero_eff  = clear_now | hzero_reg;

        below_prefill = CMPW'(cnt_eff) < CMPW'(cfg.prefill_frames);

        rd_next     = rd_eff;
        wr_next     = wr_eff;
        cnt_next    = cnt_eff;
        primed_next = primed_eff;
        silent_next = silent_reg;
        hzero_next  = hzero_eff;

        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = wr_reg;
        mem_raddr = rd_eff;
        mem_wdata = {item.left_in, item.right_in};

        result.fresh      = 1'b0;
        result.status     = ST_OK;
        result.show_frame = 1'b0;

        if (!is_pop)
        begin
            if (cnt_reg == FULL_CNT)
            begin
                result.status = ST_DROP;
            end
            else
            begin
                mem_we   = 1'b1;
                wr_next  = (wr_reg == LAST_SLOT) ? '0 : wr_reg + 1'b1;
                cnt_next = cnt_reg + 1'b1;
            end
        end
        else
        begin
            // pick the block mode on its first pop
            if (blk)
            begin
                if (!cfg.streaming_on || (!primed_eff && below_prefill))
                begin
                    silent_next = 1'b1;
                end
                else
                begin
                    primed_next = 1'b1;
                    silent_next = 1'b0;
                end
            end

            if (silent_next)
            begin
                result.status = ST_SILENT;
            end
            else if (cnt_eff != '0)
            begin
                mem_re            = 1'b1;
                rd_next           = (rd_eff == LAST_SLOT) ? '0 : rd_eff + 1'b1;
                cnt_next          = cnt_eff - 1'b1;
                hzero_next        = 1'b0;
                result.fresh      = 1'b1;
                result.show_frame = 1'b1;
            end
            else
            begin
                // repeat the last frame taken
                result.status     = ST_UNDER;
                result.show_frame = !hzero_eff;
                primed_next       = 1'b0;
            end
        end

        result.fill_level = FILL_W'(cnt_next);
    end

    // advance the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg     <= '0;
            wr_reg     <= '0;
            cnt_reg    <= '0;
            primed_reg <= 1'b0;
            silent_reg <= 1'b0;
            hzero_reg  <= 1'b1;
        end
        else if (cfg.clear)
        begin
            rd_reg     <= '0;
            wr_reg     <= '0;
            cnt_reg    <= '0;
            primed_reg <= 1'b0;
            hzero_reg  <= 1'b1;
        end
        else if (accept)
        begin
            rd_reg     <= rd_next;
            wr_reg     <= wr_next;
            cnt_reg    <= cnt_next;
            primed_reg <= primed_next;
            silent_reg <= silent_next;
            hzero_reg  <= hzero_next;
        end
    end

endmodule

FILE: sv/audio_playout_jitter_buffer.sv
// ----------------------------------------------------------------------------
// audio_playout_jitter_buffer: stereo 16-bit playout FIFO with prefill
//
// Usage:
//   req channel carries push (store a frame) and pop (play a frame)
//   transactions; rsp channel returns exactly one result per request.
//   Every request is decided in the cycle it is accepted; its result sits in
//   the output register in the cycle after. One transaction per cycle is
//   sustained while rsp_ready stays high: the frame store is one memory with
//   a write port for pushes and a registered read port for pops, and the read
//   data register doubles as the held frame repeated on underflow.
//   req_ready drops only while a result waits and rsp_ready is low; the
//   pending result and the held frame stay put until it is taken.
//   Reset empties the FIFO, clears primed and the silenced flag, marks the
//   held frame empty and sets prefill_frames to 768 and streaming_on to 0.
//   The frame store is not cleared; only written entries are ever read.
//   The user must write APB registers only while no transaction is in flight;
//   it is not enforced. Writing streaming_on empties the FIFO at once.
// ----------------------------------------------------------------------------
module audio_playout_jitter_buffer
#(
    parameter int FIFO_FRAMES = 1536
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  apjb_pkg::req_item_t req_data,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output apjb_pkg::rsp_item_t rsp_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import apjb_pkg::*;

    localparam int AW = (FIFO_FRAMES > 1) ? $clog2(FIFO_FRAMES) : 1;
    localparam int CW = $clog2(FIFO_FRAMES + 1);

    cfg_t               cfg;
    result_t            result;
    result_t            res_reg;
    logic               rsp_valid_reg;
    logic               accept;
    logic               mem_we;
    logic               mem_re;
    logic [AW-1:0]      mem_waddr;
    logic [AW-1:0]      mem_raddr;
    logic [FRAME_W-1:0] mem_wdata;
    logic [FRAME_W-1:0] mem_rdata;

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;

    apjb_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    apjb_ctrl
    #(
        .FIFO_FRAMES (FIFO_FRAMES),
        .AW          (AW),
        .CW          (CW)
    )
    u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (req_data),
        .cfg       (cfg),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .result    (result)
    );

    apjb_frame_ram
    #(
        .DEPTH (FIFO_FRAMES),
        .AW    (AW)
    )
    u_ram
    (
        .clk   (clk),
        .we    (mem_we && accept),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re && accept),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // hold the result until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            rsp_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= result;
        end
    end

    // drive the result transaction
    assign rsp_valid           = rsp_valid_reg;
    assign rsp_data.left_out   = res_reg.show_frame ? mem_rdata[FRAME_W-1:SAMPLE_W] : '0;
    assign rsp_data.right_out  = res_reg.show_frame ? mem_rdata[SAMPLE_W-1:0] : '0;
    assign rsp_data.fresh      = res_reg.fresh;
    assign rsp_data.status     = res_reg.status;
    assign rsp_data.fill_level = res_reg.fill_level;

endmodule
